>>> design/frmd_pkg.sv
// ----------------------------------------------------------------------------
// frmd_pkg
// Constants and codes shared by the frame receiver / motor drive block and
// its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frmd_pkg;

    // frame bytes
    localparam logic [7:0] HDR_BYTE  = 8'h66;
    localparam logic [7:0] TAIL_BYTE = 8'h99;

    // motor pin patterns
    localparam logic [7:0] PAT_FWD   = 8'haa;
    localparam logic [7:0] PAT_REV   = 8'h55;
    localparam logic [7:0] PAT_RIGHT = 8'ha5;
    localparam logic [7:0] PAT_LEFT  = 8'h5a;
    localparam logic [7:0] PAT_STOP  = 8'h00;

    // pulse length bases and the neutral byte value
    localparam logic [7:0] FWD_BASE  = 8'ha0;
    localparam logic [7:0] REV_BASE  = 8'h60;
    localparam logic [7:0] MID_VALUE = 8'h80;

    // frame byte positions and the tail position
    localparam logic [2:0] IDX_SPEED = 3'd3;
    localparam logic [2:0] IDX_STEER = 3'd4;
    localparam logic [2:0] IDX_TAIL  = 3'd7;

    // drive phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ON   = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;

    // frame status codes
    localparam logic [1:0] FS_NONE = 2'd0;
    localparam logic [1:0] FS_GOOD = 2'd1;
    localparam logic [1:0] FS_BAD  = 2'd2;

    // item operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register indexes
    localparam logic [2:0] REG_FWD_THR  = 3'd0;
    localparam logic [2:0] REG_REV_THR  = 3'd1;
    localparam logic [2:0] REG_RGT_THR  = 3'd2;
    localparam logic [2:0] REG_LFT_THR  = 3'd3;
    localparam logic [2:0] REG_TURN_ON  = 3'd4;
    localparam logic [2:0] REG_TURN_GAP = 3'd5;
    localparam logic [2:0] REG_DRV_GAP  = 3'd6;

    // register reset values
    localparam logic [7:0] RST_FWD_THR  = 8'd176;
    localparam logic [7:0] RST_REV_THR  = 8'd64;
    localparam logic [7:0] RST_RGT_THR  = 8'd208;
    localparam logic [7:0] RST_LFT_THR  = 8'd32;
    localparam logic [7:0] RST_TURN_ON  = 8'd20;
    localparam logic [7:0] RST_TURN_GAP = 8'd5;
    localparam logic [7:0] RST_DRV_GAP  = 8'd32;

endpackage

>>> design/frame_rx_motor_pulse_drive.sv
// ----------------------------------------------------------------------------
// frame_rx_motor_pulse_drive
// Serial command frame receiver with a tick-driven pulsed motor sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_in_valid / o_in_ready) carries one item per transaction:
//   i_operation = 0 with a received byte in i_rx_byte, or i_operation = 1 for
//   one time tick. Every item yields exactly one result on the output channel
//   (o_out_valid / i_out_ready): motor pins, drive phase and frame status.
//   configuration channel (i_cfg_valid / o_cfg_ready) writes one of seven
//   8-bit registers by index; it is always ready, index 7 is dropped.
//   Write it only while no item is in flight.
// Pipeline:
//   an item passes the input register, then the result register; one item
//   per cycle sustained while the receiver keeps i_out_ready high, since the
//   frame and drive state are computed between those two registers and
//   update together with the result register.
// Reset:
//   synchronous, active low; registers return to their defaults, the frame
//   receiver waits for a header, speed and steer go to 0x80, the drive is
//   idle with pins stop, and both pipeline stages are empty.
// Stall:
//   while a result waits, one more item is held in the input register, after
//   which o_in_ready drops until the receiver takes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_rx_motor_pulse_drive (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_operation,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_motor_pins,
    output logic [1:0] o_drive_phase,
    output logic [1:0] o_frame_status,
    // configuration channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    // configuration registers
    logic [7:0] r_fwd_thr, r_rev_thr, r_rgt_thr, r_lft_thr;
    logic [7:0] r_turn_on, r_turn_gap, r_drv_gap;

    // input stage
    logic       r_in_valid;
    logic       r_in_op;
    logic [7:0] r_in_byte;

    // block state
    logic       r_receiving, n_receiving;
    logic [2:0] r_byte_index, n_byte_index;
    logic [7:0] r_speed, n_speed;
    logic [7:0] r_steer, n_steer;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_count, n_count;
    logic [7:0] r_pins, n_pins;
    logic [1:0] n_status;

    // result stage
    logic       r_out_valid;
    logic [7:0] r_out_pins;
    logic [1:0] r_out_phase;
    logic [1:0] r_out_status;

    logic       w_advance;
    logic       w_in_take;
    logic       w_cfg_take;
    logic [7:0] w_fwd_on;
    logic [7:0] w_rev_on;
    logic       w_turn;
    logic [7:0] w_end_gap;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_in_take  = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_take  = i_cfg_valid && o_cfg_ready;

    assign w_fwd_on  = (r_speed > frmd_pkg::FWD_BASE) ? r_speed - frmd_pkg::FWD_BASE : 8'd0;
    assign w_rev_on  = (r_speed < frmd_pkg::REV_BASE) ? frmd_pkg::REV_BASE - r_speed : 8'd0;
    assign w_turn    = (r_pins == frmd_pkg::PAT_RIGHT) || (r_pins == frmd_pkg::PAT_LEFT);
    assign w_end_gap = w_turn ? r_turn_gap : r_drv_gap;

    always_comb begin
        n_receiving  = r_receiving;
        n_byte_index = r_byte_index;
        n_speed      = r_speed;
        n_steer      = r_steer;
        n_phase      = r_phase;
        n_count      = r_count;
        n_pins       = r_pins;
        n_status     = frmd_pkg::FS_NONE;

        if (r_in_op == frmd_pkg::OP_TICK) begin
            unique case (r_phase)
                frmd_pkg::PH_ON: begin
                    if (r_count > 8'd1) begin
                        n_count = r_count - 8'd1;
                    end else begin
                        n_pins = frmd_pkg::PAT_STOP;
                        if (w_end_gap != 8'd0) begin
                            n_phase = frmd_pkg::PH_GAP;
                            n_count = w_end_gap;
                        end else begin
                            n_phase = frmd_pkg::PH_IDLE;
                            n_count = 8'd0;
                        end
                    end
                end
                frmd_pkg::PH_GAP: begin
                    n_pins = frmd_pkg::PAT_STOP;
                    if (r_count > 8'd1) begin
                        n_count = r_count - 8'd1;
                    end else begin
                        n_phase = frmd_pkg::PH_IDLE;
                        n_count = 8'd0;
                    end
                end
                default: begin
                    // idle, and the unused code treated as idle
                    logic [7:0] v_pat;
                    logic [7:0] v_on;
                    logic [7:0] v_gap;
                    logic       v_go;
                    v_go  = 1'b1;
                    v_pat = frmd_pkg::PAT_STOP;
                    v_on  = 8'd0;
                    v_gap = 8'd0;
                    priority if (r_speed > r_fwd_thr) begin
                        v_pat = frmd_pkg::PAT_FWD;
                        v_on  = w_fwd_on;
                        v_gap = r_drv_gap;
                    end else if (r_speed < r_rev_thr) begin
                        v_pat = frmd_pkg::PAT_REV;
                        v_on  = w_rev_on;
                        v_gap = r_drv_gap;
                    end else if (r_steer > r_rgt_thr) begin
                        v_pat = frmd_pkg::PAT_RIGHT;
                        v_on  = r_turn_on;
                        v_gap = r_turn_gap;
                    end else if (r_steer < r_lft_thr) begin
                        v_pat = frmd_pkg::PAT_LEFT;
                        v_on  = r_turn_on;
                        v_gap = r_turn_gap;
                    end else begin
                        v_go = 1'b0;
                    end
                    n_phase = frmd_pkg::PH_IDLE;
                    n_count = 8'd0;
                    n_pins  = frmd_pkg::PAT_STOP;
                    if (v_go) begin
                        if (v_on != 8'd0) begin
                            n_phase = frmd_pkg::PH_ON;
                            n_count = v_on;
                            n_pins  = v_pat;
                        end else if (v_gap != 8'd0) begin
                            // zero on ticks: straight into the gap
                            n_phase = frmd_pkg::PH_GAP;
                            n_count = v_gap;
                        end
                    end
                end
            endcase
        end else begin
            if (!r_receiving) begin
                if (r_in_byte == frmd_pkg::HDR_BYTE) begin
                    n_receiving  = 1'b1;
                    n_byte_index = 3'd0;
                end
            end else begin
                n_byte_index = r_byte_index + 3'd1;
                if (n_byte_index == frmd_pkg::IDX_SPEED) begin
                    n_speed = r_in_byte;
                end
                if (n_byte_index == frmd_pkg::IDX_STEER) begin
                    n_steer = r_in_byte;
                end
                if (n_byte_index == frmd_pkg::IDX_TAIL) begin
                    n_status     = (r_in_byte == frmd_pkg::TAIL_BYTE) ?
                                   frmd_pkg::FS_GOOD : frmd_pkg::FS_BAD;
                    n_receiving  = 1'b0;
                    n_byte_index = 3'd0;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_thr  <= frmd_pkg::RST_FWD_THR;
            r_rev_thr  <= frmd_pkg::RST_REV_THR;
            r_rgt_thr  <= frmd_pkg::RST_RGT_THR;
            r_lft_thr  <= frmd_pkg::RST_LFT_THR;
            r_turn_on  <= frmd_pkg::RST_TURN_ON;
            r_turn_gap <= frmd_pkg::RST_TURN_GAP;
            r_drv_gap  <= frmd_pkg::RST_DRV_GAP;
        end else if (w_cfg_take) begin
            unique case (i_cfg_index)
                frmd_pkg::REG_FWD_THR:  r_fwd_thr  <= i_cfg_data;
                frmd_pkg::REG_REV_THR:  r_rev_thr  <= i_cfg_data;
                frmd_pkg::REG_RGT_THR:  r_rgt_thr  <= i_cfg_data;
                frmd_pkg::REG_LFT_THR:  r_lft_thr  <= i_cfg_data;
                frmd_pkg::REG_TURN_ON:  r_turn_on  <= i_cfg_data;
                frmd_pkg::REG_TURN_GAP: r_turn_gap <= i_cfg_data;
                frmd_pkg::REG_DRV_GAP:  r_drv_gap  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op   <= i_operation;
            r_in_byte <= i_rx_byte;
        end
    end

    // state and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_receiving  <= 1'b0;
            r_byte_index <= 3'd0;
            r_speed      <= frmd_pkg::MID_VALUE;
            r_steer      <= frmd_pkg::MID_VALUE;
            r_phase      <= frmd_pkg::PH_IDLE;
            r_count      <= 8'd0;
            r_pins       <= frmd_pkg::PAT_STOP;
            r_out_valid  <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_receiving  <= n_receiving;
                r_byte_index <= n_byte_index;
                r_speed      <= n_speed;
                r_steer      <= n_steer;
                r_phase      <= n_phase;
                r_count      <= n_count;
                r_pins       <= n_pins;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out_pins   <= n_pins;
            r_out_phase  <= n_phase;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_motor_pins   = r_out_pins;
    assign o_drive_phase  = r_out_phase;
    assign o_frame_status = r_out_status;

endmodule

>>> design/frmd_checker.sv
// ----------------------------------------------------------------------------
// frmd_checker
// Port-level checks for the frame receiver / motor drive block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frmd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_motor_pins,
    input logic [1:0] o_drive_phase,
    input logic [1:0] o_frame_status
);

    // a stalled result transaction stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
        $stable(o_motor_pins) && $stable(o_drive_phase) && $stable(o_frame_status))
        else $error("result payload changed while stalled");

    // outside a pulse the pins must be stopped
    a_stop_off_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_drive_phase != frmd_pkg::PH_ON) |->
        o_motor_pins == frmd_pkg::PAT_STOP)
        else $error("pins driven outside a pulse");

    // during a pulse the pins carry one of the four patterns
    a_pulse_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_drive_phase == frmd_pkg::PH_ON) |->
        (o_motor_pins == frmd_pkg::PAT_FWD) || (o_motor_pins == frmd_pkg::PAT_REV) ||
        (o_motor_pins == frmd_pkg::PAT_RIGHT) || (o_motor_pins == frmd_pkg::PAT_LEFT))
        else $error("pulse without a drive pattern");

endmodule

bind frame_rx_motor_pulse_drive frmd_checker u_frmd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_motor_pins   (o_motor_pins),
    .o_drive_phase  (o_drive_phase),
    .o_frame_status (o_frame_status)
);

>>> tb/frame_rx_motor_pulse_drive_tb.sv
// ----------------------------------------------------------------------------
// frame_rx_motor_pulse_drive_tb
// Self-checking bench for the serial frame receiver with pulsed motor drive.
// A short table of directed items runs first. Random bursts of well-formed
// frames, stray bytes, cut-short frames and tick runs follow, under four
// handshake profiles and four register settings. Every result is checked
// against a typed want or an in-bench model of the frame receiver and the drive sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_rx_motor_pulse_drive_tb;

    localparam int         PHASE_ITEMS  = 232;
    localparam int         OPENING_ROWS = 24;
    localparam logic [2:0] REG_UNUSED   = 3'd7;
    localparam logic       ROW_ITEM     = 1'b0;
    localparam logic       ROW_CFG      = 1'b1;

    typedef struct packed {
        logic [7:0] pins;
        logic [1:0] phase;
        logic [1:0] status;
    } t_drive_result;

    typedef struct packed {
        logic          kind;
        logic          op;
        logic [2:0]    reg_idx;
        logic [7:0]    data;
        logic          typed;
        t_drive_result want;
    } t_opening_row;

    localparam t_drive_result QUIET = '{frmd_pkg::PAT_STOP, frmd_pkg::PH_IDLE,
                                        frmd_pkg::FS_NONE};

    // dut ports
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    logic       i_operation = frmd_pkg::OP_BYTE;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_motor_pins;
    logic [1:0] o_drive_phase;
    logic [1:0] o_frame_status;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = frmd_pkg::REG_FWD_THR;
    logic [7:0] i_cfg_data  = 8'h00;

    // model copy of the registers and the block state
    logic [7:0] cfg_reg [7];
    logic       rx_active;
    logic [2:0] rx_pos;
    logic [7:0] cur_speed;
    logic [7:0] cur_steer;
    logic [1:0] drv_phase;
    logic [7:0] drv_count;
    logic [7:0] drv_pins;

    t_drive_result pending_motor_results [$];

    int err_count       = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int frames_good     = 0;
    int frames_bad      = 0;
    int pulses_started  = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // directed items; want is typed only where the answer is obvious
    t_opening_row opening_rows [OPENING_ROWS] = '{
        '{ROW_ITEM, frmd_pkg::OP_TICK, REG_UNUSED, 8'h00, 1'b1, QUIET},
        // stray byte outside a frame
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'hff, 1'b1, QUIET},
        // index past the register list is dropped
        '{ROW_CFG,  frmd_pkg::OP_BYTE, REG_UNUSED, 8'h00, 1'b0, QUIET},
        '{ROW_CFG,  frmd_pkg::OP_BYTE, frmd_pkg::REG_FWD_THR, 8'h9f, 1'b0, QUIET},
        '{ROW_CFG,  frmd_pkg::OP_BYTE, frmd_pkg::REG_DRV_GAP, 8'h00, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, frmd_pkg::HDR_BYTE, 1'b0, QUIET},
        // header inside a frame is plain data
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, frmd_pkg::HDR_BYTE, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'h00, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'ha1, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'hff, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'h00, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'h55, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, frmd_pkg::TAIL_BYTE, 1'b1,
          '{frmd_pkg::PAT_STOP, frmd_pkg::PH_IDLE, frmd_pkg::FS_GOOD}},
        '{ROW_ITEM, frmd_pkg::OP_TICK, REG_UNUSED, 8'hff, 1'b1,
          '{frmd_pkg::PAT_FWD, frmd_pkg::PH_ON, frmd_pkg::FS_NONE}},
        // a new frame while the pulse is on leaves the drive alone
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, frmd_pkg::HDR_BYTE, 1'b1,
          '{frmd_pkg::PAT_FWD, frmd_pkg::PH_ON, frmd_pkg::FS_NONE}},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'h12, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'h34, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, frmd_pkg::FWD_BASE, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'h00, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'hff, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, frmd_pkg::MID_VALUE, 1'b0, QUIET},
        // bad tail, speed and steer were still taken
        '{ROW_ITEM, frmd_pkg::OP_BYTE, REG_UNUSED, 8'h98, 1'b1,
          '{frmd_pkg::PAT_FWD, frmd_pkg::PH_ON, frmd_pkg::FS_BAD}},
        // pulse ends into a zero gap, then zero on ticks
        '{ROW_ITEM, frmd_pkg::OP_TICK, REG_UNUSED, 8'h00, 1'b0, QUIET},
        '{ROW_ITEM, frmd_pkg::OP_TICK, REG_UNUSED, 8'h00, 1'b0, QUIET}
    };

    frame_rx_motor_pulse_drive i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_motor_pins   (o_motor_pins),
        .o_drive_phase  (o_drive_phase),
        .o_frame_status (o_frame_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void start_gap(input logic [7:0] gap_ticks);
        drv_pins = frmd_pkg::PAT_STOP;
        if (gap_ticks != 8'd0) begin
            drv_phase = frmd_pkg::PH_GAP;
            drv_count = gap_ticks;
        end else begin
            drv_phase = frmd_pkg::PH_IDLE;
            drv_count = 8'd0;
        end
    endfunction

    function automatic void begin_pulse(input logic [7:0] pattern, input logic [7:0] on_ticks,
                                        input logic [7:0] gap_ticks);
        if (on_ticks != 8'd0) begin
            drv_phase = frmd_pkg::PH_ON;
            drv_count = on_ticks;
            drv_pins  = pattern;
            pulses_started++;
        end else begin
            start_gap(gap_ticks);
        end
    endfunction

    // advances the frame receiver or the drive sequencer by one item
    function automatic t_drive_result next_motor_result(input logic op, input logic [7:0] b);
        t_drive_result res;
        res.status = frmd_pkg::FS_NONE;
        if (op == frmd_pkg::OP_TICK) begin
            if (drv_phase == frmd_pkg::PH_ON) begin
                if (drv_count > 8'd1) begin
                    drv_count = drv_count - 8'd1;
                end else if (drv_pins == frmd_pkg::PAT_RIGHT ||
                             drv_pins == frmd_pkg::PAT_LEFT) begin
                    start_gap(cfg_reg[frmd_pkg::REG_TURN_GAP]);
                end else begin
                    start_gap(cfg_reg[frmd_pkg::REG_DRV_GAP]);
                end
            end else if (drv_phase == frmd_pkg::PH_GAP) begin
                drv_pins = frmd_pkg::PAT_STOP;
                if (drv_count > 8'd1) begin
                    drv_count = drv_count - 8'd1;
                end else begin
                    drv_phase = frmd_pkg::PH_IDLE;
                    drv_count = 8'd0;
                end
            end else begin
                drv_phase = frmd_pkg::PH_IDLE;
                drv_count = 8'd0;
                if (cur_speed > cfg_reg[frmd_pkg::REG_FWD_THR]) begin
                    begin_pulse(frmd_pkg::PAT_FWD,
                                (cur_speed > frmd_pkg::FWD_BASE) ?
                                cur_speed - frmd_pkg::FWD_BASE : 8'd0,
                                cfg_reg[frmd_pkg::REG_DRV_GAP]);
                end else if (cur_speed < cfg_reg[frmd_pkg::REG_REV_THR]) begin
                    begin_pulse(frmd_pkg::PAT_REV,
                                (cur_speed < frmd_pkg::REV_BASE) ?
                                frmd_pkg::REV_BASE - cur_speed : 8'd0,
                                cfg_reg[frmd_pkg::REG_DRV_GAP]);
                end else if (cur_steer > cfg_reg[frmd_pkg::REG_RGT_THR]) begin
                    begin_pulse(frmd_pkg::PAT_RIGHT, cfg_reg[frmd_pkg::REG_TURN_ON],
                                cfg_reg[frmd_pkg::REG_TURN_GAP]);
                end else if (cur_steer < cfg_reg[frmd_pkg::REG_LFT_THR]) begin
                    begin_pulse(frmd_pkg::PAT_LEFT, cfg_reg[frmd_pkg::REG_TURN_ON],
                                cfg_reg[frmd_pkg::REG_TURN_GAP]);
                end else begin
                    drv_pins = frmd_pkg::PAT_STOP;
                end
            end
        end else if (!rx_active) begin
            if (b == frmd_pkg::HDR_BYTE) begin
                rx_active = 1'b1;
                rx_pos    = 3'd0;
            end
        end else begin
            rx_pos = rx_pos + 3'd1;
            if (rx_pos == frmd_pkg::IDX_SPEED) cur_speed = b;
            if (rx_pos == frmd_pkg::IDX_STEER) cur_steer = b;
            if (rx_pos == frmd_pkg::IDX_TAIL) begin
                res.status = (b == frmd_pkg::TAIL_BYTE) ? frmd_pkg::FS_GOOD : frmd_pkg::FS_BAD;
                if (b == frmd_pkg::TAIL_BYTE) frames_good++;
                else frames_bad++;
                rx_active = 1'b0;
                rx_pos    = 3'd0;
            end
        end
        res.pins  = drv_pins;
        res.phase = drv_phase;
        return res;
    endfunction

    // byte near a threshold pair, a pulse-length base, the neutral value, an extreme, or random
    function automatic logic [7:0] pick_level(input logic [7:0] hi_thr, input logic [7:0] lo_thr);
        case ($urandom_range(0, 9))
            0: return hi_thr + 8'd1;
            1: return hi_thr;
            2: return lo_thr - 8'd1;
            3: return lo_thr;
            4: return 8'h00;
            5: return 8'hff;
            6: return frmd_pkg::FWD_BASE + 8'($urandom_range(0, 1));
            7: return frmd_pkg::REV_BASE - 8'($urandom_range(0, 1));
            8: return frmd_pkg::MID_VALUE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic push_item(input logic op, input logic [7:0] b, input logic typed,
                             input t_drive_result want);
        t_drive_result model_res;
        int gap_cycles;
        gap_cycles = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap_cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap_cycles) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_rx_byte   <= b;
        do @(posedge i_clk); while (!o_in_ready);
        model_res = next_motor_result(op, b);
        pending_motor_results.push_back(typed ? want : model_res);
        items_sent++;
    endtask

    task automatic feed(input logic op, input logic [7:0] b);
        push_item(op, b, 1'b0, QUIET);
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_motor_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= frmd_pkg::REG_DRV_GAP) cfg_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_drive_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_motor_results.size() == 0) begin
                flag_mismatch("unexpected result, pins", o_motor_pins, 0);
            end else begin
                want = pending_motor_results.pop_front();
                results_checked++;
                if (o_motor_pins !== want.pins)
                    flag_mismatch("motor_pins", o_motor_pins, want.pins);
                if (o_drive_phase !== want.phase)
                    flag_mismatch("drive_phase", o_drive_phase, want.phase);
                if (o_frame_status !== want.status)
                    flag_mismatch("frame_status", o_frame_status, want.status);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        logic [7:0] phase_cfg [4][7];
        logic [7:0] b;
        int         r;
        int         n;
        int         phase_end;
        bit         paused;

        cfg_reg[frmd_pkg::REG_FWD_THR]  = frmd_pkg::RST_FWD_THR;
        cfg_reg[frmd_pkg::REG_REV_THR]  = frmd_pkg::RST_REV_THR;
        cfg_reg[frmd_pkg::REG_RGT_THR]  = frmd_pkg::RST_RGT_THR;
        cfg_reg[frmd_pkg::REG_LFT_THR]  = frmd_pkg::RST_LFT_THR;
        cfg_reg[frmd_pkg::REG_TURN_ON]  = frmd_pkg::RST_TURN_ON;
        cfg_reg[frmd_pkg::REG_TURN_GAP] = frmd_pkg::RST_TURN_GAP;
        cfg_reg[frmd_pkg::REG_DRV_GAP]  = frmd_pkg::RST_DRV_GAP;
        rx_active = 1'b0;
        rx_pos    = 3'd0;
        cur_speed = frmd_pkg::MID_VALUE;
        cur_steer = frmd_pkg::MID_VALUE;
        drv_phase = frmd_pkg::PH_IDLE;
        drv_count = 8'd0;
        drv_pins  = frmd_pkg::PAT_STOP;

        // fwd, rev, right, left, turn on, turn gap, drive gap
        phase_cfg[0] = '{8'hb0, 8'h40, 8'hd0, 8'h20, 8'd4, 8'd2, 8'd6};
        // turns only, shortest pulse, no gaps
        phase_cfg[1] = '{8'hff, 8'h00, 8'h80, 8'h7f, 8'd1, 8'd0, 8'd0};
        // thresholds and lengths at the far ends
        phase_cfg[2] = '{8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff};
        phase_cfg[3] = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom_range(1, 12)), 8'($urandom_range(0, 8)),
                         8'($urandom_range(0, 8))};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < OPENING_ROWS; i++) begin
            if (opening_rows[i].kind == ROW_CFG) begin
                settle_idle();
                write_reg(opening_rows[i].reg_idx, opening_rows[i].data);
            end else begin
                push_item(opening_rows[i].op, opening_rows[i].data, opening_rows[i].typed,
                          opening_rows[i].want);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            settle_idle();
            sender_idle_pct = (ph == 1) ? 60 : (ph == 3) ? 25 : 0;
            recv_stall_pct  = (ph == 2) ? 60 : (ph == 3) ? 25 : 0;
            for (int ri = 0; ri <= frmd_pkg::REG_DRV_GAP; ri++)
                write_reg(3'(ri), phase_cfg[ph][ri]);
            phase_end = items_sent + PHASE_ITEMS;
            paused = 1'b0;
            while (items_sent < phase_end) begin
                // hold off once until the pipe is empty
                if (ph == 1 && !paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
                    settle_idle();
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    feed(frmd_pkg::OP_BYTE, frmd_pkg::HDR_BYTE);
                    for (int k = 1; k <= frmd_pkg::IDX_TAIL; k++) begin
                        if ($urandom_range(0, 99) < 15) feed(frmd_pkg::OP_TICK, 8'($urandom));
                        if (k == frmd_pkg::IDX_SPEED)
                            b = pick_level(cfg_reg[frmd_pkg::REG_FWD_THR],
                                           cfg_reg[frmd_pkg::REG_REV_THR]);
                        else if (k == frmd_pkg::IDX_STEER)
                            b = pick_level(cfg_reg[frmd_pkg::REG_RGT_THR],
                                           cfg_reg[frmd_pkg::REG_LFT_THR]);
                        else if (k == frmd_pkg::IDX_TAIL)
                            b = ($urandom_range(0, 99) < 85) ? frmd_pkg::TAIL_BYTE :
                                8'($urandom);
                        else
                            b = 8'($urandom);
                        feed(frmd_pkg::OP_BYTE, b);
                    end
                    n = $urandom_range(1, 30);
                    repeat (n) feed(frmd_pkg::OP_TICK, 8'($urandom));
                end else if (r < 70) begin
                    n = $urandom_range(1, 4);
                    repeat (n) feed(frmd_pkg::OP_BYTE, 8'($urandom));
                end else if (r < 85) begin
                    // cut-short frame, later items finish it
                    feed(frmd_pkg::OP_BYTE, frmd_pkg::HDR_BYTE);
                    n = $urandom_range(1, 6);
                    repeat (n) feed(frmd_pkg::OP_BYTE, 8'($urandom));
                end else begin
                    n = $urandom_range(1, 40);
                    repeat (n) feed(frmd_pkg::OP_TICK, 8'($urandom));
                end
            end
        end

        settle_idle();
        $display("ran %0d items (%0d directed) under four handshake profiles, %0d results checked",
                 items_sent, OPENING_ROWS - 3, results_checked);
        $display("frames with good tail %0d, bad tail %0d, drive pulses started %0d",
                 frames_good, frames_bad, pulses_started);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
